// ===== sv/bkfs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bkfs_pkg
// Shared types and constants of the free cell selector: word layouts,
// command codes, default grid size and column scan chunk.
// ----------------------------------------------------------------------------
package bkfs_pkg;

  localparam int KindW   = 2;
  localparam int RowW    = 5;
  localparam int ColW    = 5;
  localparam int RankW   = 10;
  localparam int TotalW  = 11;

  localparam int DefRows = 32;
  localparam int DefCols = 32;

  // columns examined per cycle by the row scanner
  localparam int ScanChunk = 8;

  localparam logic [KindW-1:0] KindOccupy = 2'd0;
  localparam logic [KindW-1:0] KindFree   = 2'd1;
  localparam logic [KindW-1:0] KindSelect = 2'd2;

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [RowW-1:0]  cell_row;
    logic [ColW-1:0]  cell_col;
    logic [RankW-1:0] rank;
  } in_word_t;

  typedef struct packed {
    logic              found;
    logic [RowW-1:0]   found_row;
    logic [ColW-1:0]   found_col;
    logic [TotalW-1:0] free_total;
  } out_word_t;

  typedef struct packed {
    logic             start;
    logic [RankW-1:0] left;
  } scan_req_t;

endpackage

// ===== sv/bitmap_kth_free_cell_select.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_kth_free_cell_select
// Occupancy bitmap of ROWS x COLS cells with mark and select-by-rank words.
//
//   channel | direction | handshake             | word
//   --------+-----------+-----------------------+-----------
//   in      | input     | in_valid_i/in_ready_o | in_word_t
//   out     | output    | out_valid_o/out_ready_i | out_word_t
//
// Mark word: row read, then write back. Select word: the row walk reads
// one bitmap row per cycle from the RAM, then the row scan takes 8 columns
// per cycle. Reset clears per-row valid bits, so no clearing pass is needed.
// A finished result waits in the output register; a later select stalls in
// its last state only while that register is still full.
// ----------------------------------------------------------------------------
module bitmap_kth_free_cell_select #(
  parameter int ROWS = bkfs_pkg::DefRows,
  parameter int COLS = bkfs_pkg::DefCols
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  bkfs_pkg::in_word_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output bkfs_pkg::out_word_t out_word_o
);
  import bkfs_pkg::*;

  localparam int RowAw = ROWS > 1 ? $clog2(ROWS) : 1;
  localparam int ColAw = COLS > 1 ? $clog2(COLS) : 1;
  localparam int CntW  = $clog2(COLS + 1);
  localparam int TotW  = $clog2(ROWS * COLS + 1);
  localparam int CbW   = $clog2(((COLS + ScanChunk - 1) / ScanChunk) * ScanChunk);

  typedef enum logic [4:0] {
    StIdle = 5'b00001,
    StMark = 5'b00010,
    StWalk = 5'b00100,
    StScan = 5'b01000,
    StDone = 5'b10000
  } state_e;

  state_e           state_q, state_d;
  logic [ROWS-1:0]  row_vld_q;
  logic [RowAw:0]   issue_q;
  logic             pv_q;
  logic [RowAw-1:0] pr_q;
  logic             rv_q;
  logic             hit_q;
  logic             scan_start_q;
  logic             out_valid_q;

  logic [RowAw-1:0] mark_row_q;
  logic [ColAw-1:0] mark_col_q;
  logic             mark_set_q;
  logic [RankW-1:0] left_q;
  logic [TotW-1:0]  total_q;
  logic [RowAw-1:0] sel_row_q;
  logic [COLS-1:0]  sel_bits_q;
  out_word_t        pend_q;
  out_word_t        out_q;

  logic             acc;
  logic             in_rng;
  logic             issuing;
  logic             ram_re;
  logic [RowAw-1:0] ram_raddr;
  logic [COLS-1:0]  ram_rdata;
  logic [COLS-1:0]  row_cur;
  logic [COLS-1:0]  row_free;
  logic [COLS-1:0]  bit_mask;
  logic [COLS-1:0]  ram_wdata;
  logic             ram_we;
  logic [CntW-1:0]  cnt;
  logic [TotW-1:0]  tot_nx;
  logic             row_hit;
  logic             walk_end;
  logic             out_load;
  scan_req_t        scan_req;
  logic             scan_done;
  logic [CbW-1:0]   scan_col;

  assign in_ready_o = state_q == StIdle;
  assign acc        = in_valid_i && in_ready_o;
  assign in_rng     = (32'(in_word_i.cell_row) < ROWS) && (32'(in_word_i.cell_col) < COLS);

  assign issuing   = (state_q == StWalk) && (32'(issue_q) < ROWS);
  assign ram_re    = acc || issuing;
  assign ram_raddr = (state_q == StIdle) ? RowAw'(in_word_i.cell_row) : issue_q[RowAw-1:0];

  assign row_cur   = rv_q ? ram_rdata : '0;
  assign row_free  = ~row_cur;
  assign bit_mask  = COLS'(1) << mark_col_q;
  assign ram_wdata = mark_set_q ? (row_cur | bit_mask) : (row_cur & ~bit_mask);
  assign ram_we    = state_q == StMark;

  assign cnt      = CntW'($countones(row_free));
  assign tot_nx   = TotW'(total_q + TotW'(cnt));
  assign row_hit  = !hit_q && (32'(left_q) < 32'(cnt));
  assign walk_end = pv_q && (pr_q == RowAw'(ROWS - 1));
  assign out_load = (state_q == StDone) && (!out_valid_q || out_ready_i);

  assign scan_req.start = scan_start_q;
  assign scan_req.left  = left_q;

  bkfs_ram #(
    .WIDTH (COLS),
    .DEPTH (ROWS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (mark_row_q),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  bkfs_col_scan #(
    .COLS (COLS)
  ) u_col_scan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (scan_req),
    .bits_i (sel_bits_q),
    .done_o (scan_done),
    .col_o  (scan_col)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (acc) begin
          if (in_word_i.kind == KindSelect) begin
            state_d = StWalk;
          end else if ((in_word_i.kind == KindOccupy || in_word_i.kind == KindFree)
                       && in_rng) begin
            state_d = StMark;
          end
        end
      end
      StMark: state_d = StIdle;
      StWalk: begin
        if (walk_end) begin
          state_d = (hit_q || row_hit) ? StScan : StDone;
        end
      end
      StScan: begin
        if (scan_done) begin
          state_d = StDone;
        end
      end
      StDone: begin
        if (out_load) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      row_vld_q    <= '0;
      issue_q      <= '0;
      pv_q         <= 1'b0;
      hit_q        <= 1'b0;
      scan_start_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      pv_q         <= issuing;
      scan_start_q <= (state_q == StWalk) && walk_end && (hit_q || row_hit);
      if (ram_we) begin
        row_vld_q[mark_row_q] <= 1'b1;
      end
      if (acc) begin
        issue_q <= '0;
        hit_q   <= 1'b0;
      end else begin
        if (issuing) begin
          issue_q <= issue_q + 1'b1;
        end
        if (pv_q && row_hit) begin
          hit_q <= 1'b1;
        end
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ram_re) begin
      rv_q <= row_vld_q[ram_raddr];
      pr_q <= ram_raddr;
    end
    if (acc) begin
      mark_row_q <= RowAw'(in_word_i.cell_row);
      mark_col_q <= ColAw'(in_word_i.cell_col);
      mark_set_q <= in_word_i.kind == KindOccupy;
      left_q     <= in_word_i.rank;
      total_q    <= '0;
    end else if (pv_q && (state_q == StWalk)) begin
      total_q <= tot_nx;
      if (row_hit) begin
        sel_row_q  <= pr_q;
        sel_bits_q <= row_free;
      end else if (!hit_q) begin
        left_q <= left_q - RankW'(cnt);
      end
    end
    if ((state_q == StWalk) && walk_end && !(hit_q || row_hit)) begin
      pend_q.found      <= 1'b0;
      pend_q.found_row  <= '0;
      pend_q.found_col  <= '0;
      pend_q.free_total <= TotalW'(tot_nx);
    end else if ((state_q == StScan) && scan_done) begin
      pend_q.found      <= 1'b1;
      pend_q.found_row  <= RowW'(sel_row_q);
      pend_q.found_col  <= ColW'(scan_col);
      pend_q.free_total <= TotalW'(total_q);
    end
    if (out_load) begin
      out_q <= pend_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

// ===== sv/bkfs_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bkfs_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module bkfs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                          wdata_i,
  input  logic                                      re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/bkfs_col_scan.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bkfs_col_scan
// Finds the column of the left-th free bit of one row, one chunk of
// columns per cycle.
// ----------------------------------------------------------------------------
module bkfs_col_scan #(
  parameter int COLS = bkfs_pkg::DefCols
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  bkfs_pkg::scan_req_t                     req_i,
  input  logic [COLS-1:0]                         bits_i,
  output logic                                    done_o,
  output logic [$clog2(((COLS + bkfs_pkg::ScanChunk - 1) / bkfs_pkg::ScanChunk)
                       * bkfs_pkg::ScanChunk)-1:0] col_o
);
  import bkfs_pkg::*;

  localparam int NChunk = (COLS + ScanChunk - 1) / ScanChunk;
  localparam int PadW   = NChunk * ScanChunk;
  localparam int CbW    = $clog2(PadW);
  localparam int OffW   = $clog2(ScanChunk);
  localparam int CcW    = $clog2(ScanChunk + 1);

  logic [PadW-1:0]      bits_q;
  logic [RankW-1:0]     left_q;
  logic [CbW-1:0]       base_q;
  logic                 busy_q;
  logic                 done_q;
  logic [CbW-1:0]       col_q;

  logic [ScanChunk-1:0] chunk;
  logic [CcW-1:0]       ccnt;
  logic                 hit;
  logic [OffW-1:0]      off;
  logic [OffW:0]        seen;
  logic                 got;

  assign chunk = bits_q[ScanChunk-1:0];
  assign ccnt  = CcW'($countones(chunk));
  assign hit   = 32'(left_q) < 32'(ccnt);

  always_comb begin
    off  = '0;
    seen = '0;
    got  = 1'b0;
    for (int i = 0; i < ScanChunk; i++) begin
      if (chunk[i] && !got) begin
        if (seen == {1'b0, left_q[OffW-1:0]}) begin
          off = OffW'(i);
          got = 1'b1;
        end else begin
          seen = seen + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
      end else if (busy_q && hit) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      bits_q <= PadW'(bits_i);
      left_q <= req_i.left;
      base_q <= '0;
    end else if (busy_q) begin
      if (hit) begin
        col_q <= CbW'(base_q + CbW'(off));
      end else begin
        bits_q <= bits_q >> ScanChunk;
        left_q <= left_q - RankW'(ccnt);
        base_q <= CbW'(base_q + CbW'(ScanChunk));
      end
    end
  end

  assign done_o = done_q;
  assign col_o  = col_q;

endmodule

// ===== sv/bkfs_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bkfs_chk
// Port-level checks of the free cell selector, bound to the top level.
// ----------------------------------------------------------------------------
module bkfs_chk (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input bkfs_pkg::in_word_t  in_word_i,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input bkfs_pkg::out_word_t out_word_o
);
  import bkfs_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_word_o))
    else $error("out word dropped or changed while stalled");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_word_o.found |-> out_word_o.found_row == '0
                                         && out_word_o.found_col == '0)
    else $error("miss word carries a cell position");

  a_hit_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.found |-> out_word_o.free_total != '0)
    else $error("hit word with zero free total");

  a_mark_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_word_i.kind != KindSelect |=> !$rose(out_valid_o))
    else $error("mark word produced a result word");

endmodule

bind bitmap_kth_free_cell_select bkfs_chk u_bkfs_chk (.*);
